/* design/mbsl_pkg.sv */
// Shared types and constants for the Modbus slave frame handler.
// No dependencies; the parser, builder, top level and checker refer to this package.
package mbsl_pkg;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_last;
	} frame_item_t;

	typedef struct packed {
		logic [31:0] resp_word;
		logic [2:0]  resp_bytes;
		logic        resp_last;
	} resp_item_t;

	// configuration register indexes
	localparam logic [1:0] CFG_SLAVE_ADDRESS  = 2'd0;
	localparam logic [1:0] CFG_REGISTER_COUNT = 2'd1;
	localparam logic [1:0] CFG_TRUNC_CODE     = 2'd2;

	typedef struct packed {
		logic [7:0] slave_address;
		logic [8:0] register_count;
		logic [7:0] truncated_frame_code;
	} cfg_regs_t;

	// function codes
	localparam logic [7:0] FN_READ_INPUT  = 8'd4;
	localparam logic [7:0] FN_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FN_WRITE_MULTI = 8'd16;

	localparam logic [15:0] MAX_READ_QTY  = 16'h007D;
	localparam logic [15:0] MAX_WRITE_QTY = 16'h007B;
	localparam logic [7:0]  EXC_FLAG      = 8'h80;

	// exception codes
	localparam logic [7:0] EXC_NONE             = 8'd0;
	localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'd1;
	localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'd2;
	localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'd3;

	typedef enum logic [1:0] {
		JOB_EXC,
		JOB_ECHO,
		JOB_READ
	} job_kind_t;

	// one reply to build, handed from the parser to the reply builder
	typedef struct packed {
		job_kind_t   kind;
		logic [7:0]  station;
		logic [7:0]  fn;
		logic [7:0]  code;
		logic [15:0] start;
		logic [15:0] qty;
	} job_t;

endpackage

/* design/mbsl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbsl_ram #(
	parameter int W     = 16,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/mbsl_fifo.sv */
// Small generic first-in first-out queue with full and empty flags.
// No dependencies.
module mbsl_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	logic [W-1:0]  mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          push_ok;
	logic          pop_ok;

	assign full    = (count_q == (PW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				count_q <= count_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/mbsl_front.sv */
// Request parser: takes frame bytes, applies writes to the register bank,
// clears the bank after reset and queues at most one reply job per frame. Uses mbsl_pkg.
module mbsl_front #(
	parameter int REGISTER_DEPTH = 256,
	localparam int AW = (REGISTER_DEPTH > 1) ? $clog2(REGISTER_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbsl_pkg::frame_item_t frame,
	output logic                 full,
	input  mbsl_pkg::cfg_regs_t  cfg,
	output logic                 job_push,
	output mbsl_pkg::job_t       job,
	input  logic                 job_full,
	input  logic                 read_done,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [15:0]          ram_wdata
);

	localparam logic [16:0] DEPTH17 = 17'(REGISTER_DEPTH);

	logic [8:0]  pos_q;
	logic [7:0]  station_q, fn_q, hi_q, exc_q;
	logic [15:0] start_q, qty_q;
	logic        fin_q;
	logic        clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic [1:0]  reads_out_q;

	logic [7:0]  b;
	logic        accept;
	logic [7:0]  station_n, fn_n, hi_n, exc_n;
	logic [15:0] start_n, qty_n;
	logic        fin_n;
	logic        wr_en;
	logic [15:0] wr_addr, wr_data;
	logic [8:0]  off;
	logic [7:0]  k;
	logic [15:0] multi_addr;
	logic [16:0] rc17, lim, rd_end;
	logic [17:0] expected, pos_inc;
	logic        reply;

	function automatic logic addr_ok(input logic [15:0] a, input logic [8:0] rc);
		return ({1'b0, a} < {8'b0, rc}) && ({1'b0, a} < DEPTH17);
	endfunction

	assign b      = frame.frame_byte;
	assign full   = clr_busy_q || job_full || (reads_out_q != 2'd0);
	assign accept = push && !full;

	always_comb begin
		station_n  = station_q;
		fn_n       = fn_q;
		start_n    = start_q;
		qty_n      = qty_q;
		hi_n       = hi_q;
		exc_n      = exc_q;
		fin_n      = fin_q;
		wr_en      = 1'b0;
		wr_addr    = start_q;
		wr_data    = {hi_q, b};
		off        = pos_q - 9'd7;
		k          = off[8:1];
		multi_addr = start_q + {8'b0, k};
		if (pos_q == 9'd0) begin
			station_n = b;
		end else if (pos_q == 9'd1) begin
			fn_n = b;
			if (station_q == cfg.slave_address && b != mbsl_pkg::FN_READ_INPUT &&
			    b != mbsl_pkg::FN_WRITE_SINGLE && b != mbsl_pkg::FN_WRITE_MULTI) begin
				exc_n = mbsl_pkg::EXC_ILLEGAL_FUNCTION;
			end
		end else if (station_q == cfg.slave_address && exc_q == mbsl_pkg::EXC_NONE &&
		             !fin_q) begin
			if (pos_q == 9'd2 || pos_q == 9'd3) begin
				start_n = {start_q[7:0], b};
			end else if (pos_q == 9'd4 || pos_q == 9'd5) begin
				qty_n = {qty_q[7:0], b};
				if (pos_q == 9'd5 && fn_q == mbsl_pkg::FN_READ_INPUT) begin
					if (qty_n == 16'd0 || qty_n > mbsl_pkg::MAX_READ_QTY) begin
						exc_n = mbsl_pkg::EXC_ILLEGAL_VALUE;
					end else begin
						fin_n = 1'b1;
					end
				end else if (pos_q == 9'd5 && fn_q == mbsl_pkg::FN_WRITE_SINGLE) begin
					if (addr_ok(start_q, cfg.register_count)) begin
						wr_en   = 1'b1;
						wr_addr = start_q;
						wr_data = qty_n;
						fin_n   = 1'b1;
					end else begin
						exc_n = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
					end
				end
			end else if (fn_q == mbsl_pkg::FN_WRITE_MULTI && pos_q == 9'd6) begin
				if (qty_q == 16'd0 || qty_q > mbsl_pkg::MAX_WRITE_QTY ||
				    {9'b0, b} != {qty_q, 1'b0}) begin
					exc_n = mbsl_pkg::EXC_ILLEGAL_VALUE;
				end
			end else if (fn_q == mbsl_pkg::FN_WRITE_MULTI && pos_q >= 9'd7) begin
				if (!off[0]) begin
					hi_n = b;
				end else if (addr_ok(multi_addr, cfg.register_count)) begin
					wr_en   = 1'b1;
					wr_addr = multi_addr;
					wr_data = {hi_q, b};
					if ({8'b0, k} + 16'd1 == qty_q) begin
						fin_n = 1'b1;
					end
				end else begin
					exc_n = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
				end
			end
		end
	end

	// reply decision on the final byte
	always_comb begin
		rc17     = {8'b0, cfg.register_count};
		lim      = (rc17 < DEPTH17) ? rc17 : DEPTH17;
		rd_end   = {1'b0, start_n} + {1'b0, qty_n};
		expected = (fn_n == mbsl_pkg::FN_WRITE_MULTI) ? 18'd7 + {1'b0, qty_n, 1'b0} : 18'd6;
		pos_inc  = {9'b0, pos_q} + 18'd1;
		job.kind    = mbsl_pkg::JOB_EXC;
		job.station = station_n;
		job.fn      = fn_n;
		job.code    = exc_n;
		job.start   = start_n;
		job.qty     = qty_n;
		reply       = 1'b0;
		if (pos_q != 9'd0 && station_n == cfg.slave_address) begin
			if (exc_n != mbsl_pkg::EXC_NONE) begin
				reply = 1'b1;
			end else if (!fin_n) begin
				reply    = 1'b1;
				job.code = cfg.truncated_frame_code;
			end else if (fn_n == mbsl_pkg::FN_READ_INPUT && rd_end > lim) begin
				reply    = 1'b1;
				job.code = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
			end else if (pos_inc == expected) begin
				reply    = 1'b1;
				job.kind = (fn_n == mbsl_pkg::FN_READ_INPUT) ? mbsl_pkg::JOB_READ :
				                                              mbsl_pkg::JOB_ECHO;
			end
		end
	end

	assign job_push  = accept && frame.frame_last && reply;
	assign ram_we    = clr_busy_q || (accept && wr_en);
	assign ram_waddr = clr_busy_q ? clr_addr_q : wr_addr[AW-1:0];
	assign ram_wdata = clr_busy_q ? 16'd0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			station_q   <= '0;
			fn_q        <= '0;
			start_q     <= '0;
			qty_q       <= '0;
			hi_q        <= '0;
			exc_q       <= '0;
			fin_q       <= 1'b0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			reads_out_q <= '0;
		end else begin
			if (clr_busy_q) begin
				if (clr_addr_q == AW'(REGISTER_DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			if (job_push && job.kind == mbsl_pkg::JOB_READ && !read_done) begin
				reads_out_q <= reads_out_q + 1'b1;
			end else if (read_done && !(job_push && job.kind == mbsl_pkg::JOB_READ)) begin
				reads_out_q <= reads_out_q - 1'b1;
			end
			if (accept) begin
				if (frame.frame_last) begin
					pos_q     <= '0;
					station_q <= '0;
					fn_q      <= '0;
					start_q   <= '0;
					qty_q     <= '0;
					hi_q      <= '0;
					exc_q     <= '0;
					fin_q     <= 1'b0;
				end else begin
					pos_q     <= (pos_q == 9'd511) ? pos_q : pos_q + 9'd1;
					station_q <= station_n;
					fn_q      <= fn_n;
					start_q   <= start_n;
					qty_q     <= qty_n;
					hi_q      <= hi_n;
					exc_q     <= exc_n;
					fin_q     <= fin_n;
				end
			end
		end
	end

endmodule

/* design/mbsl_back.sv */
// Reply builder: turns one job into response bytes, fetches register data
// from the bank and packs bytes four to a result item, the last one of a reply possibly short. Uses mbsl_pkg.
module mbsl_back #(
	parameter int REGISTER_DEPTH = 256,
	localparam int AW = (REGISTER_DEPTH > 1) ? $clog2(REGISTER_DEPTH) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 job_empty,
	input  mbsl_pkg::job_t       job,
	output logic                 job_pop,
	output logic                 read_done,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  logic [15:0]          ram_rdata,
	output logic                 out_push,
	output mbsl_pkg::resp_item_t out_item,
	input  logic                 out_full
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FETCH
	} state_t;

	state_t         state_q;
	mbsl_pkg::job_t job_q;
	logic [7:0]     j_q, n_q;
	logic [31:0]    acc_q;
	logic [1:0]     cnt_q;
	logic [15:0]    data_q;
	logic           have_q;

	logic [7:0]  jm3;
	logic [7:0]  byte_v;
	logic [7:0]  n_new;
	logic        need_fetch;
	logic        feed;
	logic        final_byte;
	logic [31:0] word_n;
	logic [15:0] rd_addr;

	assign jm3        = j_q - 8'd3;
	assign need_fetch = job_q.kind == mbsl_pkg::JOB_READ && j_q >= 8'd3 && !jm3[0] && !have_q;
	assign feed       = state_q == ST_RUN && !need_fetch && !out_full;
	assign final_byte = j_q == n_q - 8'd1;
	assign rd_addr    = job_q.start + {9'b0, jm3[7:1]};

	assign job_pop   = state_q == ST_IDLE && !job_empty;
	assign ram_re    = state_q == ST_RUN && need_fetch;
	assign ram_raddr = rd_addr[AW-1:0];
	assign read_done = feed && final_byte && job_q.kind == mbsl_pkg::JOB_READ;

	always_comb begin
		case (job.kind)
			mbsl_pkg::JOB_EXC:  n_new = 8'd3;
			mbsl_pkg::JOB_ECHO: n_new = 8'd6;
			default:            n_new = {job.qty[6:0], 1'b0} + 8'd3;
		endcase
	end

	always_comb begin
		case (job_q.kind)
			mbsl_pkg::JOB_EXC: begin
				case (j_q)
					8'd0:    byte_v = job_q.station;
					8'd1:    byte_v = job_q.fn | mbsl_pkg::EXC_FLAG;
					default: byte_v = job_q.code;
				endcase
			end
			mbsl_pkg::JOB_ECHO: begin
				case (j_q)
					8'd0:    byte_v = job_q.station;
					8'd1:    byte_v = job_q.fn;
					8'd2:    byte_v = job_q.start[15:8];
					8'd3:    byte_v = job_q.start[7:0];
					8'd4:    byte_v = job_q.qty[15:8];
					default: byte_v = job_q.qty[7:0];
				endcase
			end
			default: begin
				case (j_q)
					8'd0:    byte_v = job_q.station;
					8'd1:    byte_v = job_q.fn;
					8'd2:    byte_v = {job_q.qty[6:0], 1'b0};
					default: byte_v = jm3[0] ? data_q[7:0] : data_q[15:8];
				endcase
			end
		endcase
	end

	always_comb begin
		word_n = acc_q;
		case (cnt_q)
			2'd0:    word_n[31:24] = byte_v;
			2'd1:    word_n[23:16] = byte_v;
			2'd2:    word_n[15:8]  = byte_v;
			default: word_n[7:0]   = byte_v;
		endcase
		out_push            = feed && (cnt_q == 2'd3 || final_byte);
		out_item.resp_word  = word_n;
		out_item.resp_bytes = {1'b0, cnt_q} + 3'd1;
		out_item.resp_last  = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= '0;
			j_q     <= '0;
			n_q     <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			data_q  <= '0;
			have_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						job_q   <= job;
						n_q     <= n_new;
						j_q     <= '0;
						acc_q   <= '0;
						cnt_q   <= '0;
						have_q  <= 1'b0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (need_fetch) begin
						state_q <= ST_FETCH;
					end else if (feed) begin
						j_q <= j_q + 8'd1;
						if (job_q.kind == mbsl_pkg::JOB_READ && j_q >= 8'd3 && jm3[0]) begin
							have_q <= 1'b0;
						end
						if (out_push) begin
							acc_q <= '0;
							cnt_q <= '0;
						end else begin
							acc_q <= word_n;
							cnt_q <= cnt_q + 2'd1;
						end
						if (final_byte) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FETCH: begin
					data_q  <= ram_rdata;
					have_q  <= 1'b1;
					state_q <= ST_RUN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/modbus_slave_frame_handler_unit.sv */
// Top level of the Modbus slave frame handler: config registers, parser,
// job queue, reply builder, register bank and result queue. Uses mbsl_pkg.
//
//  channel   handshake              payload
//  frame     push / full            frame_byte, frame_last
//  resp      empty / pop            resp_word, resp_bytes, resp_last
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The parser takes a frame byte whenever push is high and full is low. At the final
// byte a reply job is queued; the builder puts out one byte per cycle while the result
// queue has room and no fetch is under way: each register of a read reply first passes
// through a request in the run state and a fetch in the fetch state. After reset the
// bank is cleared one entry a cycle, with full high until the clear is done. full also
// stays high while a register read reply is pending, and while the job queue is full;
// a stalled result queue stalls the builder, and through the job queue also the parser.
module modbus_slave_frame_handler_unit #(
	parameter int REGISTER_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbsl_pkg::frame_item_t frame,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output mbsl_pkg::resp_item_t resp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [8:0]           cfg_data
);

	localparam int AW = (REGISTER_DEPTH > 1) ? $clog2(REGISTER_DEPTH) : 1;

	mbsl_pkg::cfg_regs_t  cfg_q;
	mbsl_pkg::job_t       job_in, job_out;
	mbsl_pkg::resp_item_t out_item;
	logic                 job_push, job_full, job_pop, job_empty;
	logic                 read_done;
	logic                 out_push, out_full;
	logic                 ram_we, ram_re;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [15:0]          ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slave_address        <= 8'd1;
			cfg_q.register_count       <= 9'd256;
			cfg_q.truncated_frame_code <= 8'd4;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				mbsl_pkg::CFG_SLAVE_ADDRESS:  cfg_q.slave_address        <= cfg_data[7:0];
				mbsl_pkg::CFG_REGISTER_COUNT: cfg_q.register_count       <= cfg_data;
				mbsl_pkg::CFG_TRUNC_CODE:     cfg_q.truncated_frame_code <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	mbsl_front #(.REGISTER_DEPTH(REGISTER_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.frame     (frame),
		.full      (full),
		.cfg       (cfg_q),
		.job_push  (job_push),
		.job       (job_in),
		.job_full  (job_full),
		.read_done (read_done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	mbsl_fifo #(.W($bits(mbsl_pkg::job_t)), .DEPTH(2)) u_job_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_out),
		.empty  (job_empty)
	);

	mbsl_ram #(.W(16), .DEPTH(REGISTER_DEPTH)) u_bank (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	mbsl_back #(.REGISTER_DEPTH(REGISTER_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (job_out),
		.job_pop   (job_pop),
		.read_done (read_done),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_push  (out_push),
		.out_item  (out_item),
		.out_full  (out_full)
	);

	mbsl_fifo #(.W($bits(mbsl_pkg::resp_item_t)), .DEPTH(2)) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.full   (out_full),
		.pop    (pop),
		.rdata  (resp),
		.empty  (empty)
	);

endmodule

/* design/mbsl_checker.sv */
// Port-level checks for the Modbus slave frame handler, bound to the top level.
// Uses mbsl_pkg.
module mbsl_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input mbsl_pkg::frame_item_t frame,
	input logic                 full,
	input logic                 empty,
	input logic                 pop,
	input mbsl_pkg::resp_item_t resp,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [1:0]           cfg_index,
	input logic [8:0]           cfg_data
);

	// a waiting result holds until taken
	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(resp)))
		else $error("result changed while waiting");

	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (resp.resp_bytes != 3'd0 && resp.resp_bytes <= 3'd4))
		else $error("resp_bytes out of range");

	// only the final item of a reply may be short
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !resp.resp_last) |-> resp.resp_bytes == 3'd4)
		else $error("short item before end of reply");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind modbus_slave_frame_handler_unit mbsl_checker u_mbsl_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the Modbus slave frame handler unit.
// Needs mbsl_pkg and modbus_slave_frame_handler_unit; drives frames, checks replies.
`timescale 1ns / 100ps

module testbench;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  push = 0;
	mbsl_pkg::frame_item_t frame = '0;
	logic                  full;
	logic                  empty;
	logic                  pop = 0;
	mbsl_pkg::resp_item_t  resp;
	logic                  cfg_valid = 0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [8:0]            cfg_data = '0;

	modbus_slave_frame_handler_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .frame(frame), .full(full),
		.empty(empty), .pop(pop), .resp(resp), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// slave-side state mirror
	logic [7:0]  my_station;
	logic [8:0]  reg_limit;
	logic [7:0]  short_code;
	logic [15:0] bank [256];
	int unsigned bpos;
	logic [7:0]  st_b, fn_b, hi_b, exc;
	logic [15:0] sa, qty;
	logic        done;

	mbsl_pkg::frame_item_t byte_queue[$];
	mbsl_pkg::resp_item_t  reply_queue[$];
	int          errors = 0;
	int          n_bytes = 0, n_replies = 0;
	int          stall_hold = 0;
	int          burst = 0, gap = 0;
	int          idle_cycles = 0;
	bit          drain_req = 0;

	function automatic bit reg_ok(logic [15:0] a);
		return a < reg_limit && a < 256;
	endfunction

	function automatic void reset_frame();
		bpos = 0; st_b = 0; fn_b = 0; sa = 0; qty = 0;
		hi_b = 0; exc = mbsl_pkg::EXC_NONE; done = 0;
	endfunction

	// advance the mirror by one frame byte and queue any reply words
	function automatic void predict_reply(mbsl_pkg::frame_item_t it);
		logic [7:0]  b;
		logic [7:0]  buf8 [$];
		logic [7:0]  code;
		logic [15:0] a;
		int unsigned p, k, expect_len, i;
		bit          ex;
		mbsl_pkg::resp_item_t r;
		b = it.frame_byte;
		p = bpos;
		if (p == 0) st_b = b;
		else if (p == 1) begin
			fn_b = b;
			if (st_b == my_station && b != mbsl_pkg::FN_READ_INPUT &&
				b != mbsl_pkg::FN_WRITE_SINGLE && b != mbsl_pkg::FN_WRITE_MULTI)
				exc = mbsl_pkg::EXC_ILLEGAL_FUNCTION;
		end else if (st_b == my_station && exc == mbsl_pkg::EXC_NONE && !done) begin
			if (p == 2 || p == 3) sa = {sa[7:0], b};
			else if (p == 4 || p == 5) begin
				qty = {qty[7:0], b};
				if (p == 5 && fn_b == mbsl_pkg::FN_READ_INPUT) begin
					if (qty < 1 || qty > mbsl_pkg::MAX_READ_QTY)
						exc = mbsl_pkg::EXC_ILLEGAL_VALUE;
					else done = 1;
				end else if (p == 5 && fn_b == mbsl_pkg::FN_WRITE_SINGLE) begin
					if (reg_ok(sa)) begin
						bank[sa[7:0]] = qty;
						done = 1;
					end else exc = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
				end
			end else if (fn_b == mbsl_pkg::FN_WRITE_MULTI && p == 6) begin
				if (qty < 1 || qty > mbsl_pkg::MAX_WRITE_QTY || {8'd0, b} != qty * 2)
					exc = mbsl_pkg::EXC_ILLEGAL_VALUE;
			end else if (fn_b == mbsl_pkg::FN_WRITE_MULTI && p >= 7) begin
				if (((p - 7) & 1) == 0) hi_b = b;
				else begin
					k = (p - 7) >> 1;
					a = sa + k[15:0];
					if (reg_ok(a)) begin
						bank[a[7:0]] = {hi_b, b};
						if (k + 1 == qty) done = 1;
					end else exc = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
				end
			end
		end
		bpos = (p < 511) ? p + 1 : 511;
		if (!it.frame_last) return;
		if (p >= 1 && st_b == my_station) begin
			code = exc;
			ex = (code != mbsl_pkg::EXC_NONE);
			if (!ex && !done) begin
				ex = 1;
				code = short_code;
			end
			if (!ex && fn_b == mbsl_pkg::FN_READ_INPUT)
				for (i = 0; i < qty; i++)
					if (!ex && !reg_ok(sa + i[15:0])) begin
						ex = 1;
						code = mbsl_pkg::EXC_ILLEGAL_ADDRESS;
					end
			buf8.push_back(st_b);
			if (ex) begin
				buf8.push_back(fn_b | mbsl_pkg::EXC_FLAG);
				buf8.push_back(code);
			end else begin
				expect_len = (fn_b == mbsl_pkg::FN_WRITE_MULTI) ? 7 + 2 * qty : 6;
				if (p + 1 == expect_len) begin
					buf8.push_back(fn_b);
					if (fn_b == mbsl_pkg::FN_READ_INPUT) begin
						buf8.push_back({qty[6:0], 1'b0});
						for (i = 0; i < qty; i++) begin
							a = sa + i[15:0];
							buf8.push_back(bank[a[7:0]][15:8]);
							buf8.push_back(bank[a[7:0]][7:0]);
						end
					end else begin
						buf8.push_back(sa[15:8]); buf8.push_back(sa[7:0]);
						buf8.push_back(qty[15:8]); buf8.push_back(qty[7:0]);
					end
				end else buf8.delete();
			end
		end
		while (buf8.size() > 0) begin
			r = '0;
			for (i = 0; i < 4 && buf8.size() > 0; i++) begin
				r.resp_word[31 - 8 * i -: 8] = buf8.pop_front();
				r.resp_bytes = 3'(i + 1);
			end
			r.resp_last = (buf8.size() == 0);
			reply_queue.push_back(r);
		end
		reset_frame();
	endfunction

	// driver: bursts with gaps, optional drain pause
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_reply(frame);
				n_bytes++;
				void'(byte_queue.pop_front());
			end
			if (burst == 0 && gap == 0) begin
				burst = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			end
			if (byte_queue.size() > 0 && !drain_req && (gap == 0 || burst > 0)) begin
				push <= 1;
				frame <= byte_queue[0];
				if (burst > 0) burst--;
			end else begin
				push <= 0;
				if (gap > 0) gap--;
			end
		end
	end

	// monitor: compare accepted replies, random stalls plus one long hold-off
	always @(posedge clk) begin
		mbsl_pkg::resp_item_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				n_replies++;
				if (reply_queue.size() == 0) begin
					$error("unexpected reply word %h", resp);
					errors++;
				end else begin
					want = reply_queue.pop_front();
					if (resp.resp_word !== want.resp_word) begin
						$error("resp_word: expected %h, got %h", want.resp_word, resp.resp_word);
						errors++;
					end
					if (resp.resp_bytes !== want.resp_bytes) begin
						$error("resp_bytes: expected %0d, got %0d", want.resp_bytes,
							resp.resp_bytes);
						errors++;
					end
					if (resp.resp_last !== want.resp_last) begin
						$error("resp_last: expected %0d, got %0d", want.resp_last,
							resp.resp_last);
						errors++;
					end
				end
			end
			if (stall_hold > 0) begin
				stall_hold--;
				pop <= 0;
			end else
				pop <= ($urandom_range(0, 7) < 5) || (n_replies % 64 < 16);
		end
	end

	// watchdog on accepted items
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("modbus_slave_frame_handler_unit test failed");
			$finish;
		end
	end

	task automatic add_frame(input logic [7:0] bytes [$]);
		mbsl_pkg::frame_item_t it;
		for (int i = 0; i < bytes.size(); i++) begin
			it.frame_byte = bytes[i];
			it.frame_last = (i == bytes.size() - 1);
			byte_queue.push_back(it);
		end
	endtask

	task automatic wait_quiet();
		while (byte_queue.size() > 0 || push) @(posedge clk);
		while (reply_queue.size() > 0) @(posedge clk);
		repeat (1200) @(posedge clk);
	endtask

	// one write, then a wait with cfg_valid low so back-to-back writes never collide
	task automatic write_cfg(input logic [1:0] idx, input logic [8:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			mbsl_pkg::CFG_SLAVE_ADDRESS:  my_station = val[7:0];
			mbsl_pkg::CFG_REGISTER_COUNT: reg_limit = val;
			default:                      short_code = val[7:0];
		endcase
		@(posedge clk);
	endtask

	// well-formed or broken request frame with random content
	task automatic random_frame();
		logic [7:0]  f [$];
		logic [15:0] s, q;
		int          kind;
		kind = $urandom_range(0, 9);
		s = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 255));
		f.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom : {24'd0, my_station}));
		case (kind)
			0, 1, 2: begin
				q = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) :
					$urandom_range(1, 8));
				f.push_back(mbsl_pkg::FN_READ_INPUT);
				f.push_back(s[15:8]); f.push_back(s[7:0]);
				f.push_back(q[15:8]); f.push_back(q[7:0]);
			end
			3, 4: begin
				q = 16'($urandom);
				f.push_back(mbsl_pkg::FN_WRITE_SINGLE);
				f.push_back(s[15:8]); f.push_back(s[7:0]);
				f.push_back(q[15:8]); f.push_back(q[7:0]);
			end
			5, 6: begin
				q = 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) :
					$urandom_range(1, 5));
				f.push_back(mbsl_pkg::FN_WRITE_MULTI);
				f.push_back(s[15:8]); f.push_back(s[7:0]);
				f.push_back(q[15:8]); f.push_back(q[7:0]);
				f.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : {q[6:0], 1'b0});
				for (int i = 0; i < 2 * q && i < 20; i++) f.push_back(8'($urandom));
			end
			default: begin
				f.push_back(8'($urandom));
				repeat ($urandom_range(0, 8)) f.push_back(8'($urandom));
			end
		endcase
		if ($urandom_range(0, 7) == 0 && f.size() > 1)
			f = f[0:$urandom_range(0, f.size() - 2)];
		else if ($urandom_range(0, 9) == 0)
			f.push_back(8'($urandom));
		add_frame(f);
	endtask

	initial begin
		my_station = 1; reg_limit = 256; short_code = 4;
		foreach (bank[i]) bank[i] = 0;
		reset_frame();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: every function, exceptions, edge fields
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_SINGLE, 8'h00, 8'h00, 8'hFF, 8'hFF});
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_MULTI, 8'h00, 8'hFE, 8'h00, 8'h02, 8'h04,
			8'hA5, 8'h5A, 8'h00, 8'h80});
		add_frame('{8'h01, mbsl_pkg::FN_READ_INPUT, 8'h00, 8'hFD, 8'h00, 8'h03});
		add_frame('{8'h01, mbsl_pkg::FN_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h7D});
		add_frame('{8'h01, mbsl_pkg::FN_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h7E});
		add_frame('{8'h01, mbsl_pkg::FN_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h00});
		add_frame('{8'h01, mbsl_pkg::FN_READ_INPUT, 8'hFF, 8'hFF, 8'h00, 8'h02});
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h7C, 8'hF8});
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h01, 8'h03});
		add_frame('{8'h01, 8'h03});
		add_frame('{8'h01});
		add_frame('{8'h00, mbsl_pkg::FN_WRITE_SINGLE, 8'h00, 8'h05, 8'h12, 8'h34});
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_SINGLE, 8'h00});
		add_frame('{8'h01, mbsl_pkg::FN_WRITE_SINGLE, 8'h00, 8'h01, 8'h00, 8'h01, 8'h77});
		wait_quiet();

		write_cfg(mbsl_pkg::CFG_SLAVE_ADDRESS, 9'd247);
		write_cfg(mbsl_pkg::CFG_REGISTER_COUNT, 9'd0);
		write_cfg(mbsl_pkg::CFG_TRUNC_CODE, 9'd0);
		add_frame('{8'hF7, mbsl_pkg::FN_WRITE_SINGLE, 8'h00, 8'h00, 8'h11, 8'h22});
		add_frame('{8'hF7, mbsl_pkg::FN_READ_INPUT, 8'h00});
		add_frame('{8'hF7, mbsl_pkg::FN_WRITE_MULTI, 8'h00, 8'h00, 8'h00, 8'h01, 8'h02,
			8'h01, 8'h02});
		wait_quiet();

		// fill the output while the input keeps offering
		write_cfg(mbsl_pkg::CFG_REGISTER_COUNT, 9'd256);
		write_cfg(mbsl_pkg::CFG_TRUNC_CODE, 9'd255);
		stall_hold = 600;
		repeat (6) add_frame('{8'hF7, mbsl_pkg::FN_READ_INPUT, 8'h00, 8'h00, 8'h00, 8'h40});
		wait_quiet();

		for (int phase = 0; phase < 3; phase++) begin
			write_cfg(mbsl_pkg::CFG_SLAVE_ADDRESS,
				phase == 0 ? 9'd1 : 9'($urandom_range(1, 247)));
			write_cfg(mbsl_pkg::CFG_REGISTER_COUNT,
				phase == 1 ? 9'd256 : 9'($urandom_range(0, 300)));
			write_cfg(mbsl_pkg::CFG_TRUNC_CODE, 9'($urandom_range(0, 255)));
			repeat (10) random_frame();
			drain_req = 1;
			while (byte_queue.size() > 0) begin
				drain_req = (reply_queue.size() > 0);
				@(posedge clk);
			end
			drain_req = 0;
			wait_quiet();
		end

		$display("covered %0d frame bytes and %0d reply words over several settings",
			n_bytes, n_replies);
		if (errors == 0)
			$display("modbus_slave_frame_handler_unit test passed");
		else
			$display("modbus_slave_frame_handler_unit test failed");
		$finish;
	end
endmodule
